/* src/pffl_pkg.sv */
// Shared constants, types and helper functions for the page frame allocator.
package pffl_pkg;

  localparam int MAX_PAGES  = 65536;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W  = 32;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int OFS_W   = $clog2(PAGE_BYTES);
  localparam int PAGE_W  = $clog2(MAX_PAGES);
  localparam int CNT_W   = $clog2(MAX_PAGES + 1);
  localparam int FRESH_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int FPAGE_W = ADDR_W - OFS_W;
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] TOTAL_RESET    = CFG_W'(65536);
  localparam logic [CFG_W-1:0] RESERVED_RESET = CFG_W'(0);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_PAGE = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic {
    BK_RUN,
    BK_WAIT
  } bk_state_t;

  typedef struct packed {
    req_t              kind;
    logic              unknown;
    logic [PAGE_W-1:0] page;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CFG_W-1:0] reserved;
    logic             restart;
    logic [CFG_W-1:0] restart_fresh;
  } cfg_t;

  function automatic logic [CNT_W-1:0] limit_total(input logic [CFG_W-1:0] t);
    logic [CNT_W-1:0] r;
    if (32'(t) > 32'(MAX_PAGES)) begin
      r = CNT_W'(MAX_PAGES);
    end else begin
      r = CNT_W'(t);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] page_to_addr(input logic [FRESH_W-1:0] p);
    logic [63:0] w;
    w = 64'(p) << OFS_W;
    return w[ADDR_W-1:0];
  endfunction

endpackage

/* src/pffl_if.sv */
// Request and response channel interfaces of the page frame allocator.
interface pffl_req_if
  import pffl_pkg::*;
();
  logic              valid;
  logic              ready;
  req_t              req_type;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, output req_type, output free_address, input ready);
  modport sink   (input valid, input req_type, input free_address, output ready);
endinterface

interface pffl_rsp_if
  import pffl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] page_address;
  status_t           status;

  modport source (output valid, output page_address, output status, input ready);
  modport sink   (input valid, input page_address, input status, output ready);
endinterface

/* src/pffl_front.sv */
// Front end: accepts requests and classifies frees against the page total.
module pffl_front
  import pffl_pkg::*;
(
  pffl_req_if.sink        in_req,
  input  logic [CNT_W-1:0] total,
  input  logic             cq_ready,
  output logic             cq_push,
  output cmd_t             cq_cmd
);

  logic [FPAGE_W-1:0] addr_page;

  assign addr_page    = in_req.free_address[ADDR_W-1:OFS_W];
  assign in_req.ready = cq_ready;
  assign cq_push      = in_req.valid && cq_ready;

  always_comb begin
    cq_cmd.kind    = in_req.req_type;
    cq_cmd.page    = PAGE_W'(addr_page);
    cq_cmd.unknown = (32'(addr_page) >= 32'(total));
  end

endmodule

/* src/pffl_cmdq.sv */
// Short command queue between the front end and the back end.
module pffl_cmdq
  import pffl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic ready,
  input  logic pop,
  output logic valid,
  output cmd_t head_cmd
);

  cmd_t                entry_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign ready    = (cnt_r != CQ_CNT_W'(CQ_DEPTH));
  assign valid    = (cnt_r != '0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* src/pffl_back.sv */
// Back end: fresh page counter, returned-page ring and response register.
module pffl_back
  import pffl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cq_valid,
  input  cmd_t cq_cmd,
  output logic cq_pop,
  pffl_rsp_if.source out_rsp
);

  logic [PAGE_W-1:0] ring_mem [MAX_PAGES];
  logic [PAGE_W-1:0] rdata_r;

  bk_state_t          state_r, state_nxt;
  logic [FRESH_W-1:0] fresh_r, fresh_nxt;
  logic [PAGE_W-1:0]  head_r, head_nxt;
  logic [PAGE_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  status_t           out_status_r, out_status_nxt;

  logic out_free;
  logic rd_en;
  logic wr_en;
  logic fresh_avail;

  assign out_free    = !out_valid_r || out_rsp.ready;
  assign fresh_avail = fresh_r < FRESH_W'(cfg.total);

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.page_address = out_addr_r;
  assign out_rsp.status       = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    fresh_nxt      = fresh_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    cq_pop         = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    unique case (state_r)
      BK_RUN: begin
        if (cq_valid && out_free) begin
          cq_pop         = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = ST_OK;
          if (cq_cmd.kind == REQ_FREE) begin
            out_valid_nxt = 1'b1;
            if (cq_cmd.unknown) begin
              out_status_nxt = ST_UNKNOWN;
            end else if (count_r == CNT_W'(MAX_PAGES)) begin
              out_status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              tail_nxt  = (tail_r == PAGE_W'(MAX_PAGES - 1)) ? '0 : tail_r + 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else if (fresh_avail) begin
            out_valid_nxt = 1'b1;
            out_addr_nxt  = page_to_addr(fresh_r);
            fresh_nxt     = fresh_r + 1'b1;
          end else if (count_r != '0) begin
            rd_en     = 1'b1;
            head_nxt  = (head_r == PAGE_W'(MAX_PAGES - 1)) ? '0 : head_r + 1'b1;
            count_nxt = count_r - 1'b1;
            state_nxt = BK_WAIT;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NO_PAGE;
          end
        end
      end
      BK_WAIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = page_to_addr(FRESH_W'(rdata_r));
          out_status_nxt = ST_OK;
          state_nxt      = BK_RUN;
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase
    if (cfg.restart) begin
      fresh_nxt = FRESH_W'(cfg.restart_fresh);
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      fresh_r     <= FRESH_W'(RESERVED_RESET);
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fresh_r     <= fresh_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[tail_r] <= cq_cmd.page;
    end
    if (rd_en) begin
      rdata_r <= ring_mem[head_r];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PAGES))
    else $error("returned-page count exceeds ring capacity");

  a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == BK_WAIT) && !cq_pop)
    else $error("ring read not followed by a wait for its data");

  a_wait_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WAIT && out_free) |=> out_valid_r && out_status_r == ST_OK)
    else $error("ring allocation did not produce an ok response");

  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.restart |=> count_r == '0 && head_r == tail_r)
    else $error("restart did not empty the returned-page ring");

endmodule

/* src/page_frame_free_list_allocator.sv */
// Top level of the page frame allocator: configuration registers and block wiring.
// Path: a fresh page, a free or a failure passes the command queue and the response
// register; a page from the returned-page ring also passes the registered ring read.
// Throughput: one request per cycle from fresh pages and frees while responses are taken;
// an allocation from the ring holds the back end in its wait state for the ring read.
// Reset: synchronous, active low; total 65536 pages, none reserved, ring empty.
module page_frame_free_list_allocator
  import pffl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  pffl_req_if.sink             in_req,
  pffl_rsp_if.source           out_rsp
);

  logic [CFG_W-1:0] total_r, total_nxt;
  logic [CFG_W-1:0] reserved_r, reserved_nxt;
  cfg_t             cfg;
  logic             cq_push, cq_ready, cq_pop, cq_valid;
  cmd_t             cq_in_cmd, cq_head_cmd;

  always_comb begin
    total_nxt    = total_r;
    reserved_nxt = reserved_r;
    cfg.restart  = 1'b0;
    if (cfg_we) begin
      if (cfg_index == REG_TOTAL) begin
        total_nxt   = cfg_wdata;
        cfg.restart = 1'b1;
      end else if (cfg_index == REG_RESERVED) begin
        reserved_nxt = cfg_wdata;
        cfg.restart  = 1'b1;
      end
    end
    cfg.total         = limit_total(total_r);
    cfg.reserved      = reserved_r;
    cfg.restart_fresh = reserved_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= TOTAL_RESET;
      reserved_r <= RESERVED_RESET;
    end else begin
      total_r    <= total_nxt;
      reserved_r <= reserved_nxt;
    end
  end

  pffl_front u_front (
    .in_req   (in_req),
    .total    (cfg.total),
    .cq_ready (cq_ready),
    .cq_push  (cq_push),
    .cq_cmd   (cq_in_cmd)
  );

  pffl_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cq_push),
    .push_cmd (cq_in_cmd),
    .ready    (cq_ready),
    .pop      (cq_pop),
    .valid    (cq_valid),
    .head_cmd (cq_head_cmd)
  );

  pffl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cq_valid (cq_valid),
    .cq_cmd   (cq_head_cmd),
    .cq_pop   (cq_pop),
    .out_rsp  (out_rsp)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the page frame allocator: directed table and random requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pffl_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASES         = 7;
  localparam int PHASE_REQS     = 100;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PLAN_LEN       = 30;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    status_t           status;
  } reply_t;

  typedef struct packed {
    logic   pinned;
    reply_t reply;
  } answer_t;

  typedef enum logic {
    ROW_SET,
    ROW_REQ
  } row_kind_t;

  typedef struct packed {
    row_kind_t         what;
    req_t              kind;
    logic [ADDR_W-1:0] addr;
    logic              pinned;
    logic [ADDR_W-1:0] want_addr;
    status_t           want_st;
    logic [CFG_W-1:0]  total;
    logic [CFG_W-1:0]  reserved;
  } row_t;

  row_t plan [PLAN_LEN] = '{
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_FREE,  32'h0000_1FFF, 1'b1, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_FREE,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_UNKNOWN, 17'd0,      17'd0},
    '{ROW_REQ, REQ_FREE,  32'h0FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_SET, REQ_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      17'd3,      17'd0},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_1000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_2000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_NO_PAGE, 17'd0,      17'd0},
    '{ROW_REQ, REQ_FREE,  32'h0000_2ABC, 1'b1, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_FREE,  32'h0000_3000, 1'b1, 32'h0000_0000, ST_UNKNOWN, 17'd0,      17'd0},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_2000, ST_OK,      17'd0,      17'd0},
    '{ROW_SET, REQ_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      17'd3,      17'd2},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_2000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_FREE,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_FREE,  32'h0000_0FFF, 1'b1, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_SET, REQ_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      17'd3,      17'd65536},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_NO_PAGE, 17'd0,      17'd0},
    '{ROW_REQ, REQ_FREE,  32'h0000_1000, 1'b1, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_1000, ST_OK,      17'd0,      17'd0},
    '{ROW_SET, REQ_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_NO_PAGE, 17'd0,      17'd0},
    '{ROW_REQ, REQ_FREE,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNKNOWN, 17'd0,      17'd0},
    '{ROW_SET, REQ_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,      17'd131071, 17'd65535},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0FFF_F000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_NO_PAGE, 17'd0,      17'd0},
    '{ROW_REQ, REQ_FREE,  32'h0FFF_F123, 1'b1, 32'h0000_0000, ST_OK,      17'd0,      17'd0},
    '{ROW_REQ, REQ_FREE,  32'h1000_0000, 1'b1, 32'h0000_0000, ST_UNKNOWN, 17'd0,      17'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  pffl_req_if in_req ();
  pffl_rsp_if out_rsp ();

  page_frame_free_list_allocator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_req   (in_req),
    .out_rsp  (out_rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int unsigned alloc_total;
  int unsigned alloc_reserved;
  int unsigned next_fresh;
  logic [PAGE_W-1:0] returned_pages [$];

  reply_t      pending_replies [$];
  answer_t     typed_answers [$];
  int unsigned n_offered;
  int unsigned n_checked;
  int unsigned n_mismatch;
  int unsigned n_settings;
  int unsigned idle_cycles;
  int unsigned status_seen [4];
  bit          calm;
  bit          send_choppy;
  bit          hold_armed;

  function automatic reply_t serve_request(input req_t kind, input logic [ADDR_W-1:0] addr);
    reply_t      r;
    int unsigned cap;
    int unsigned page;
    cap = (alloc_total > MAX_PAGES) ? MAX_PAGES : alloc_total;
    r.page_address = '0;
    r.status = ST_OK;
    if (kind == REQ_ALLOC) begin
      if (next_fresh < cap) begin
        page = next_fresh;
        next_fresh++;
        r.page_address = ADDR_W'(page) << OFS_W;
      end else if (returned_pages.size() != 0) begin
        page = returned_pages.pop_front();
        r.page_address = ADDR_W'(page) << OFS_W;
      end else begin
        r.status = ST_NO_PAGE;
      end
    end else begin
      page = addr >> OFS_W;
      if (page >= cap) begin
        r.status = ST_UNKNOWN;
      end else if (returned_pages.size() >= MAX_PAGES) begin
        r.status = ST_FULL;
      end else begin
        returned_pages.push_back(PAGE_W'(page));
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : observe
    answer_t tag;
    reply_t  got;
    reply_t  want;
    if (!rst_n) begin
      alloc_total = int'(TOTAL_RESET);
      alloc_reserved = int'(RESERVED_RESET);
      next_fresh = alloc_reserved;
      returned_pages.delete();
      idle_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TOTAL: begin
            alloc_total = cfg_wdata;
            next_fresh = alloc_reserved;
            returned_pages.delete();
          end
          REG_RESERVED: begin
            alloc_reserved = cfg_wdata;
            next_fresh = alloc_reserved;
            returned_pages.delete();
          end
          default: ;
        endcase
      end
      if (in_req.valid && in_req.ready) begin
        tag = typed_answers.pop_front();
        got = serve_request(in_req.req_type, in_req.free_address);
        pending_replies.push_back(tag.pinned ? tag.reply : got);
      end
      if (out_rsp.valid && out_rsp.ready) begin
        n_checked++;
        status_seen[int'(out_rsp.status)]++;
        if (pending_replies.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("Response without an outstanding request: addr %h status %0d",
                     out_rsp.page_address, out_rsp.status);
          end
        end else begin
          want = pending_replies.pop_front();
          if (out_rsp.page_address !== want.page_address || out_rsp.status !== want.status) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("Mismatch on response %0d: expected addr %h status %0d, got addr %h status %0d",
                       n_checked, want.page_address, want.status,
                       out_rsp.page_address, out_rsp.status);
            end
          end
        end
      end
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : drain
    int unsigned hold_left;
    bit          choppy;
    hold_left = 0;
    choppy = 1'b1;
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) begin
        choppy = !choppy;
      end
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_rsp.ready <= 1'b0;
      end else if (!calm && choppy && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 8);
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  task automatic apply_setting(input logic [CFG_W-1:0] total, input logic [CFG_W-1:0] reserved);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TOTAL;
    cfg_wdata <= total;
    @(posedge clk);
    cfg_index <= REG_RESERVED;
    cfg_wdata <= reserved;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic settle();
    in_req.valid <= 1'b0;
    while (n_checked < n_offered) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic offer(input req_t kind, input logic [ADDR_W-1:0] addr, input logic pinned,
                       input reply_t reply);
    in_req.valid        <= 1'b1;
    in_req.req_type     <= kind;
    in_req.free_address <= addr;
    typed_answers.push_back(answer_t'{pinned, reply});
    do @(posedge clk); while (!in_req.ready);
    n_offered++;
    if (!calm && send_choppy && $urandom_range(0, 5) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int unsigned       total;
    int unsigned       reserved;
    int unsigned       cap;
    int unsigned       page;
    int unsigned       alloc_pct;
    int unsigned       roll;
    req_t              kind;
    logic [ADDR_W-1:0] addr;
    calm = 1'b0;
    hold_armed = 1'b0;
    send_choppy = 1'b1;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_TOTAL;
    cfg_wdata           <= '0;
    in_req.valid        <= 1'b0;
    in_req.req_type     <= REQ_ALLOC;
    in_req.free_address <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].what == ROW_SET) begin
        settle();
        apply_setting(plan[i].total, plan[i].reserved);
      end else begin
        offer(plan[i].kind, plan[i].addr, plan[i].pinned,
              reply_t'{plan[i].want_addr, plan[i].want_st});
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin total = MAX_PAGES; reserved = 0; end
        1: begin total = 16; reserved = 4; end
        2: begin total = 1; reserved = 0; end
        3: begin total = 131071; reserved = 65530; end
        4: begin
          total = $urandom_range(1, MAX_PAGES);
          reserved = $urandom_range(0, total);
        end
        5: begin total = 300; reserved = 300; end
        default: begin total = 8; reserved = 0; end
      endcase
      cap = (total > MAX_PAGES) ? MAX_PAGES : total;
      settle();
      apply_setting(CFG_W'(total), CFG_W'(reserved));
      send_choppy = (ph != 1) && ($urandom_range(0, 3) != 0);
      calm = (ph == PHASES - 1);
      hold_armed = (ph == 1);
      alloc_pct = $urandom_range(35, 65);
      repeat (PHASE_REQS) begin
        kind = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
        roll = $urandom_range(0, 9);
        page = (roll < 7) ? $urandom_range(0, cap - 1) : cap - $urandom_range(0, 1);
        if (roll < 8) begin
          addr = ADDR_W'((page << OFS_W) | $urandom_range(0, PAGE_BYTES - 1));
        end else begin
          addr = $urandom();
        end
        offer(kind, addr, 1'b0, '0);
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d requests over %0d register settings, with one long response hold.",
             n_offered, n_settings);
    $display("Responses seen: %0d ok, %0d no page, %0d unknown page, %0d ring full.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (n_mismatch == 0 && pending_replies.size() == 0 && n_checked == n_offered) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
